// ===== rtl/prfh_pkg.sv =====
`timescale 1ns / 1ps

package prfh_pkg;

    localparam logic [31:0] HASH_SEED   = 32'd5381;
    localparam int          MIN_FRAME   = 24;
    localparam int          FCS_BYTES   = 4;
    localparam int          EXT_BYTES   = 4;
    localparam int          PAYLOAD_BITS = 12;

    // queue depth must stay a power of two: pointers wrap by overflow
    localparam int          QUEUE_DEPTH = 4;

    // byte positions inside the MAC header
    localparam int POS_FRAME_CTRL  = 0;
    localparam int POS_FLAGS       = 1;
    localparam int POS_ADDR2_FIRST = 10;
    localparam int POS_ADDR2_LAST  = 15;
    localparam int POS_SEQ_LOW     = 22;
    localparam int POS_SEQ_HIGH    = 23;

    typedef enum logic [7:0] {
        CFG_MATCH_TYPE    = 8'd0,
        CFG_MATCH_SUBTYPE = 8'd1,
        CFG_HEADER_LENGTH = 8'd2,
        CFG_EXT_MASK      = 8'd3
    } cfg_index_t;

    typedef struct packed {
        logic [1:0] match_type;
        logic [3:0] match_subtype;
        logic [5:0] header_length;
        logic [7:0] ext_mask;
    } cfg_t;

    typedef struct packed {
        logic [47:0]                source_address;
        logic [15:0]                sequence_control;
        logic signed [7:0]          rssi_out;
        logic [PAYLOAD_BITS-1:0]    payload_length;
        logic [31:0]                frame_hash;
        logic                       header_extended;
        logic                       length_error;
    } result_t;

    typedef struct packed {
        logic    valid;
        logic    full;
        result_t head;
    } queue_status_t;

endpackage

// ===== rtl/probe_request_filter_hash_core.sv =====
`timescale 1ns / 1ps
// Channel   Handshake              Payload
// byte      byte_valid/byte_stall  frame_byte, first_of_frame, last_of_frame,
//                                  signal_rssi, signal_length
// result    result_valid/stall     source_address, sequence_control, rssi_out,
//                                  payload_length, frame_hash, header_extended,
//                                  length_error
// config    cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One byte request per cycle while byte_stall is low: the front parses and hashes
// each byte in a single shift-add-xor step. A matching frame's result goes from its
// last byte through a four-entry result queue and then the output register.
// byte_stall rises only while the queue holds four undelivered results.
// Reset is asynchronous and active low; it restores the register defaults and
// clears the frame state at once, with no clearing pass.

module probe_request_filter_hash_core
    import prfh_pkg::*;
#(
    parameter int LENGTH_BITS = 12
)
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               byte_valid,
    output logic               byte_stall,
    input  logic [7:0]         frame_byte,
    input  logic               first_of_frame,
    input  logic               last_of_frame,
    input  logic signed [7:0]  signal_rssi,
    input  logic [11:0]        signal_length,

    output logic               result_valid,
    input  logic               result_stall,
    output logic [47:0]        source_address,
    output logic [15:0]        sequence_control,
    output logic signed [7:0]  rssi_out,
    output logic [11:0]        payload_length,
    output logic [31:0]        frame_hash,
    output logic               header_extended,
    output logic               length_error,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_index,
    input  logic [7:0]         cfg_data
);

    cfg_t          cfg_reg, cfg_next;
    logic          accept;
    logic          push;
    logic          pop;
    result_t       front_rec;
    result_t       result;
    queue_status_t queue;

    // Register file: always ready, unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MATCH_TYPE:    cfg_next.match_type    = cfg_data[1:0];
                CFG_MATCH_SUBTYPE: cfg_next.match_subtype = cfg_data[3:0];
                CFG_HEADER_LENGTH: cfg_next.header_length = cfg_data[5:0];
                CFG_EXT_MASK:      cfg_next.ext_mask      = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.match_type    <= 2'd0;
            cfg_reg.match_subtype <= 4'd4;
            cfg_reg.header_length <= 6'd24;
            cfg_reg.ext_mask      <= 8'h01;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Hold byte requests only when the result queue has no room left.
    assign byte_stall = queue.full;
    assign accept     = byte_valid && !byte_stall;

    // Front: parse fields, run the digest, classify on the last byte.
    prfh_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .accept         (accept),
        .frame_byte     (frame_byte),
        .first_of_frame (first_of_frame),
        .last_of_frame  (last_of_frame),
        .signal_rssi    (signal_rssi),
        .signal_length  (signal_length),
        .push           (push),
        .rec            (front_rec)
    );

    // Queue: decouple the byte side from a stalled result side.
    prfh_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_rec),
        .pop       (pop),
        .status    (queue)
    );

    // Back: output register toward the result consumer.
    prfh_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .queue        (queue),
        .pop          (pop),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result)
    );

    assign source_address   = result.source_address;
    assign sequence_control = result.sequence_control;
    assign rssi_out         = result.rssi_out;
    assign payload_length   = result.payload_length;
    assign frame_hash       = result.frame_hash;
    assign header_extended  = result.header_extended;
    assign length_error     = result.length_error;

endmodule

// ===== rtl/prfh_front.sv =====
`timescale 1ns / 1ps

module prfh_front
    import prfh_pkg::*;
#(
    parameter int LENGTH_BITS = 12
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              accept,
    input  logic [7:0]        frame_byte,
    input  logic              first_of_frame,
    input  logic              last_of_frame,
    input  logic signed [7:0] signal_rssi,
    input  logic [11:0]       signal_length,
    output logic              push,
    output result_t           rec
);

    localparam int LW = LENGTH_BITS;
    localparam int DW = LENGTH_BITS + 1;
    localparam logic [LW-1:0] COUNT_MAX = '1;

    logic [LW-1:0]     count_reg, count_next;
    logic [31:0]       hash_reg, hash_next;
    logic [5:0]        ts_reg, ts_next;
    logic [7:0]        flags_reg, flags_next;
    logic [47:0]       src_reg, src_next;
    logic [15:0]       seq_reg, seq_next;
    logic signed [7:0] rssi_reg, rssi_next;
    logic [LW-1:0]     len_reg, len_next;

    logic [LW-1:0]     cur_count, count_inc;
    logic [31:0]       cur_hash, hash_upd;
    logic [5:0]        cur_ts, ts_upd;
    logic [7:0]        cur_flags, flags_upd;
    logic [47:0]       cur_src, src_upd;
    logic [15:0]       cur_seq, seq_upd;
    logic [LW+11:0]    sl_pad;
    logic              hashing, frame_ok, ext, err;
    logic [6:0]        hdr;
    logic [DW-1:0]     total, need, diff;
    logic [LW+PAYLOAD_BITS-1:0] pay_pad;

    always_comb
    begin
        // a first byte restarts the frame; sample rssi and length on it
        sl_pad    = {{LW{1'b0}}, signal_length};
        cur_count = first_of_frame ? '0 : count_reg;
        cur_hash  = first_of_frame ? HASH_SEED : hash_reg;
        cur_ts    = first_of_frame ? 6'd0 : ts_reg;
        cur_flags = first_of_frame ? 8'd0 : flags_reg;
        cur_src   = first_of_frame ? 48'd0 : src_reg;
        cur_seq   = first_of_frame ? 16'd0 : seq_reg;
        rssi_next = first_of_frame ? signal_rssi : rssi_reg;
        len_next  = first_of_frame ? sl_pad[LW-1:0] : len_reg;

        // hash only bytes ahead of the FCS
        hashing  = (len_next >= LW'(FCS_BYTES)) && (cur_count < (len_next - LW'(FCS_BYTES)));
        hash_upd = hashing ? (((cur_hash << 5) + cur_hash) ^ {24'd0, frame_byte}) : cur_hash;

        ts_upd    = cur_ts;
        flags_upd = cur_flags;
        src_upd   = cur_src;
        seq_upd   = cur_seq;
        if (cur_count == LW'(POS_FRAME_CTRL))
        begin
            ts_upd = frame_byte[7:2];
        end
        else if (cur_count == LW'(POS_FLAGS))
        begin
            flags_upd = frame_byte;
        end
        else if (cur_count >= LW'(POS_ADDR2_FIRST) && cur_count <= LW'(POS_ADDR2_LAST))
        begin
            src_upd = {cur_src[39:0], frame_byte};
        end
        else if (cur_count == LW'(POS_SEQ_LOW))
        begin
            seq_upd = {cur_seq[15:8], frame_byte};
        end
        else if (cur_count == LW'(POS_SEQ_HIGH))
        begin
            seq_upd = {frame_byte, cur_seq[7:0]};
        end

        count_inc = (cur_count != COUNT_MAX) ? cur_count + LW'(1) : cur_count;

        // classify the finished frame
        frame_ok = (count_inc >= LW'(MIN_FRAME)) && (ts_upd[1:0] == cfg.match_type)
                   && (ts_upd[5:2] == cfg.match_subtype);
        ext      = |(flags_upd & cfg.ext_mask);
        hdr      = {1'b0, cfg.header_length} + (ext ? 7'(EXT_BYTES) : 7'd0);
        total    = {1'b0, len_next};
        need     = DW'(hdr) + DW'(FCS_BYTES);
        err      = total < need;
        diff     = total - need;
        pay_pad  = {{PAYLOAD_BITS{1'b0}}, diff[LW-1:0]};

        rec.source_address   = src_upd;
        rec.sequence_control = seq_upd;
        rec.rssi_out         = rssi_next;
        rec.payload_length   = err ? '0 : pay_pad[PAYLOAD_BITS-1:0];
        rec.frame_hash       = hash_upd;
        rec.header_extended  = ext;
        rec.length_error     = err;

        push = accept && last_of_frame && frame_ok;

        // drop the frame state after a last byte
        if (last_of_frame)
        begin
            count_next = '0;
            hash_next  = HASH_SEED;
            ts_next    = 6'd0;
            flags_next = 8'd0;
            src_next   = 48'd0;
            seq_next   = 16'd0;
        end
        else
        begin
            count_next = count_inc;
            hash_next  = hash_upd;
            ts_next    = ts_upd;
            flags_next = flags_upd;
            src_next   = src_upd;
            seq_next   = seq_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            hash_reg  <= HASH_SEED;
            ts_reg    <= 6'd0;
            flags_reg <= 8'd0;
            src_reg   <= 48'd0;
            seq_reg   <= 16'd0;
            rssi_reg  <= 8'sd0;
            len_reg   <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
            hash_reg  <= hash_next;
            ts_reg    <= ts_next;
            flags_reg <= flags_next;
            src_reg   <= src_next;
            seq_reg   <= seq_next;
            rssi_reg  <= rssi_next;
            len_reg   <= len_next;
        end
    end

endmodule

// ===== rtl/prfh_queue.sv =====
`timescale 1ns / 1ps

module prfh_queue
    import prfh_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  result_t       push_data,
    input  logic          pop,
    output queue_status_t status
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    result_t            entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]     fill_reg, fill_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg + (PTR_W + 1)'(push) - (PTR_W + 1)'(pop);

        status.valid = fill_reg != '0;
        status.full  = fill_reg == (PTR_W + 1)'(QUEUE_DEPTH);
        status.head  = entry_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/prfh_back.sv =====
`timescale 1ns / 1ps

module prfh_back
    import prfh_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  queue_status_t queue,
    output logic          pop,
    input  logic          result_stall,
    output logic          result_valid,
    output result_t       result
);

    logic    valid_reg, valid_next;
    result_t result_reg;

    always_comb
    begin
        // advance the head into the output register when it is free or taken
        pop        = queue.valid && (!valid_reg || !result_stall);
        valid_next = pop ? 1'b1 : (valid_reg && result_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            result_reg <= queue.head;
        end
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule
